// File: design/ips_pkg.sv
package ips_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int TAP_IDX_W  = 5;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int FACTOR_W   = 4;
  localparam int TAPS_W     = 6;

  // Register reset values.
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 4'd4;
  localparam logic [TAPS_W-1:0]   TAPS_RST   = 6'd25;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 4'd1;

  // Operation codes carried in the input tuser.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  // One complex sample, I in the low half.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] q;
    logic signed [SAMPLE_W-1:0] i;
  } iq_t;

  // Per-cycle controls broadcast along the cell row.
  typedef struct packed {
    logic adv;    // pipeline moves forward
    logic shift;  // upsampled line moves one cell
    logic load;   // upsampled line takes a new aligned pattern
    logic push;   // sample history moves one cell
    logic clear;  // sample history is wiped
  } cell_ctl_t;

  // Marks that travel with each output slot.
  typedef struct packed {
    logic valid;
    logic last;
  } slot_flags_t;

endpackage

// File: design/ips_cell.sv
module ips_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ips_pkg::cell_ctl_t              ctl,
  input  logic                            tap_we,
  input  logic signed [15:0]              tap_value,
  input  logic                            in_use,
  input  ips_pkg::iq_t                    s_prev,
  input  ips_pkg::iq_t                    u_prev,
  input  ips_pkg::iq_t                    u_load,
  output ips_pkg::iq_t                    s_out,
  output ips_pkg::iq_t                    u_out,
  output logic signed [31:0]              prod_i,
  output logic signed [31:0]              prod_q
);
  import ips_pkg::*;

  logic signed [SAMPLE_W-1:0] tap_r;
  iq_t                        s_r;
  iq_t                        u_r;
  logic signed [PROD_W-1:0]   prod_i_r;
  logic signed [PROD_W-1:0]   prod_q_r;
  logic signed [PROD_W-1:0]   prod_i_nxt;
  logic signed [PROD_W-1:0]   prod_q_nxt;

  // Tap coefficient held by this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (tap_we) begin
      tap_r <= tap_value;
    end
  end

  // Sample history entry, shifted in from the neighbor on a push.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else if (ctl.push) begin
      s_r <= s_prev;
    end else if (ctl.clear) begin
      s_r <= '0;
    end
  end

  // Zero-stuffed line entry: loaded on a new run, shifted once per output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r <= '0;
    end else if (ctl.load) begin
      u_r <= u_load;
    end else if (ctl.shift) begin
      u_r <= u_prev;
    end
  end

  // Tap times line entry; taps past the active count contribute nothing.
  always_comb begin
    prod_i_nxt = '0;
    prod_q_nxt = '0;
    if (in_use) begin
      prod_i_nxt = tap_r * $signed(u_r.i);
      prod_q_nxt = tap_r * $signed(u_r.q);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_i_r <= prod_i_nxt;
      prod_q_r <= prod_q_nxt;
    end
  end

  assign s_out  = s_r;
  assign u_out  = u_r;
  assign prod_i = prod_i_r;
  assign prod_q = prod_q_r;

endmodule

// File: design/ips_sum_tree.sv
module ips_sum_tree #(
  parameter int N    = 32,
  parameter int IN_W = 32,
  parameter int OUT_W = IN_W + $clog2(N)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic signed [IN_W-1:0]        prod_i [N],
  input  logic signed [IN_W-1:0]        prod_q [N],
  input  ips_pkg::slot_flags_t          flags_in,
  output logic signed [OUT_W-1:0]       sum_i,
  output logic signed [OUT_W-1:0]       sum_q,
  output ips_pkg::slot_flags_t          flags_out
);
  import ips_pkg::*;

  localparam int LEVELS = $clog2(N);
  localparam int SPAN   = 1 << LEVELS;

  logic signed [OUT_W-1:0] leaf_i [SPAN];
  logic signed [OUT_W-1:0] leaf_q [SPAN];
  logic signed [OUT_W-1:0] node_i_r [1:SPAN-1];
  logic signed [OUT_W-1:0] node_q_r [1:SPAN-1];
  slot_flags_t             flags_r [LEVELS];

  // Leaves: sign-extended products, zero padding up to a power of two.
  for (genvar k = 0; k < SPAN; k++) begin : g_leaf
    if (k < N) begin : g_used
      assign leaf_i[k] = OUT_W'(prod_i[k]);
      assign leaf_q[k] = OUT_W'(prod_q[k]);
    end else begin : g_pad
      assign leaf_i[k] = '0;
      assign leaf_q[k] = '0;
    end
  end

  // Registered adder nodes in heap order; node 1 is the root.
  for (genvar n = 1; n < SPAN; n++) begin : g_node
    if (2 * n >= SPAN) begin : g_bottom
      always_ff @(posedge clk) begin
        if (adv) begin
          node_i_r[n] <= leaf_i[2*n-SPAN] + leaf_i[2*n+1-SPAN];
          node_q_r[n] <= leaf_q[2*n-SPAN] + leaf_q[2*n+1-SPAN];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (adv) begin
          node_i_r[n] <= node_i_r[2*n] + node_i_r[2*n+1];
          node_q_r[n] <= node_q_r[2*n] + node_q_r[2*n+1];
        end
      end
    end
  end

  // Slot marks follow the sums level by level.
  for (genvar l = 0; l < LEVELS; l++) begin : g_flag
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        flags_r[l] <= '0;
      end else if (adv) begin
        flags_r[l] <= (l == 0) ? flags_in : flags_r[(l == 0) ? 0 : l-1];
      end
    end
  end

  assign sum_i     = node_i_r[1];
  assign sum_q     = node_q_r[1];
  assign flags_out = flags_r[LEVELS-1];

endmodule

// File: design/interpolating_pulse_shaper.sv
// Channel  Direction  Contents
// in_      slave      tdata: sample_i, sample_q, tap_index, tap_value; tuser: operation
// out_     master     tdata: out_i, out_q; tlast: last_of_run
// cfg_     slave      cfg_index, cfg_data; always ready
//
// A push issues upsample_factor outputs and a flush tap_count-1 outputs, one output
// per cycle from the cell row unless the output stalls; a tap load or an unused code
// issues none. The first result is registered through the product stage, adder tree
// and output register. Reset clears taps, history, line and control registers.
// A stalled output freezes the whole pipeline; a new item is taken in the
// cycle the previous run issues its last output.
module interpolating_pulse_shaper #(
  parameter int MAX_TAPS   = 32,
  parameter int MAX_FACTOR = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] sample_i, [31:16] sample_q, [36:32] tap_index, [52:37] tap_value
  input  logic [ips_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [1:0]                     in_tuser,
  // Output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] out_i, [31:16] out_q
  output logic [ips_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ips_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ips_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ips_pkg::*;

  localparam int FE_W    = $clog2(MAX_FACTOR + 1);
  localparam int ME_W    = $clog2(MAX_TAPS + 1);
  localparam int CNT_MAX = (MAX_TAPS > MAX_FACTOR) ? MAX_TAPS : MAX_FACTOR + 1;
  localparam int CNT_W   = $clog2(CNT_MAX);
  localparam int SUM_W   = PROD_W + $clog2(MAX_TAPS);
  localparam int RND_W   = SUM_W + 1;
  localparam int SH_W    = RND_W - 15;

  // Input fields
  logic signed [SAMPLE_W-1:0]  sample_i;
  logic signed [SAMPLE_W-1:0]  sample_q;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [SAMPLE_W-1:0]  tap_value;

  logic [FACTOR_W-1:0] factor_r;
  logic [TAPS_W-1:0]   taps_r;
  logic [FE_W-1:0]     f_eff;
  logic [ME_W-1:0]     m_eff;

  logic             adv;
  logic             busy;
  logic             in_acc;
  logic             is_load;
  logic             is_push;
  logic             is_flush;
  logic [CNT_W-1:0] run_len;

  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] rem_nxt;
  logic             slot_v_r;
  logic             slot_v_nxt;
  logic             slot_last_r;
  logic             slot_last_nxt;

  cell_ctl_t   ctl;
  slot_flags_t prod_flags_r;
  slot_flags_t tree_flags;

  iq_t                      s_hist [MAX_TAPS];
  iq_t                      u_line [MAX_TAPS];
  logic signed [PROD_W-1:0] prod_i [MAX_TAPS];
  logic signed [PROD_W-1:0] prod_q [MAX_TAPS];

  logic signed [SUM_W-1:0] sum_i;
  logic signed [SUM_W-1:0] sum_q;
  logic [RND_W-1:0]        rnd_i;
  logic [RND_W-1:0]        rnd_q;

  logic                  out_valid_r;
  logic                  out_last_r;
  logic [SAMPLE_W-1:0]   out_i_r;
  logic [SAMPLE_W-1:0]   out_q_r;

  // Clip a rounded value to 16 bits signed.
  function automatic logic [SAMPLE_W-1:0] sat16(input logic [SH_W-1:0] v);
    logic [SAMPLE_W-1:0] res;
    if ((&v[SH_W-1:SAMPLE_W-1]) || !(|v[SH_W-1:SAMPLE_W-1])) begin
      res = v[SAMPLE_W-1:0];
    end else if (v[SH_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

  assign sample_i  = in_tdata[15:0];
  assign sample_q  = in_tdata[31:16];
  assign tap_index = in_tdata[36:32];
  assign tap_value = in_tdata[52:37];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RST;
      taps_r   <= TAPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FACTOR: factor_r <= cfg_data[FACTOR_W-1:0];
        CFG_TAPS:   taps_r   <= cfg_data[TAPS_W-1:0];
        default:    ;
      endcase
    end
  end

  // Effective factor and tap count, clamped to the supported range.
  always_comb begin
    if (factor_r == '0) begin
      f_eff = FE_W'(1);
    end else if (32'(factor_r) > MAX_FACTOR) begin
      f_eff = FE_W'(MAX_FACTOR);
    end else begin
      f_eff = FE_W'(factor_r);
    end
    if (taps_r == '0) begin
      m_eff = ME_W'(1);
    end else if (32'(taps_r) > MAX_TAPS) begin
      m_eff = ME_W'(MAX_TAPS);
    end else begin
      m_eff = ME_W'(taps_r);
    end
  end

  // Handshake: the pipeline moves when the output register can take a value.
  assign adv       = !out_valid_r || out_tready;
  assign busy      = slot_v_r && (rem_r != '0);
  assign in_tready = adv && !busy;
  assign in_acc    = in_tvalid && in_tready;

  // Operation decode.
  always_comb begin
    is_load  = 1'b0;
    is_push  = 1'b0;
    is_flush = 1'b0;
    unique case (in_tuser)
      OP_LOAD:  is_load  = 1'b1;
      OP_PUSH:  is_push  = 1'b1;
      OP_FLUSH: is_flush = 1'b1;
      default:  ;
    endcase
  end

  // Number of outputs the accepted item issues.
  always_comb begin
    run_len = '0;
    if (is_push) begin
      run_len = CNT_W'(f_eff);
    end else if (is_flush) begin
      run_len = CNT_W'(m_eff - ME_W'(1));
    end
  end

  // Output slot sequencer.
  always_comb begin
    rem_nxt       = rem_r;
    slot_v_nxt    = slot_v_r;
    slot_last_nxt = slot_last_r;
    if (adv) begin
      if (busy) begin
        rem_nxt       = rem_r - CNT_W'(1);
        slot_v_nxt    = 1'b1;
        slot_last_nxt = (rem_r == CNT_W'(1));
      end else if (in_acc && (run_len != '0)) begin
        rem_nxt       = run_len - CNT_W'(1);
        slot_v_nxt    = 1'b1;
        slot_last_nxt = (run_len == CNT_W'(1));
      end else begin
        rem_nxt       = '0;
        slot_v_nxt    = 1'b0;
        slot_last_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      slot_v_r    <= 1'b0;
      slot_last_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      slot_v_r    <= slot_v_nxt;
      slot_last_r <= slot_last_nxt;
    end
  end

  // Controls for the cell row.
  always_comb begin
    ctl.adv   = adv;
    ctl.shift = adv && busy;
    ctl.load  = in_acc && !busy && (is_push || is_flush);
    ctl.push  = in_acc && is_push;
    ctl.clear = in_acc && is_flush;
  end

  // Row of cells. On a new run, cell t takes history entry t/F-1 when t is a
  // multiple of F (the push sample lands in cell 0), zero elsewhere.
  for (genvar Tc = 0; Tc < MAX_TAPS; Tc++) begin : g_cell
    iq_t  s_in;
    iq_t  u_in;
    iq_t  load_v;
    iq_t  cand [MAX_FACTOR];
    logic tap_we;
    logic in_use;

    if (Tc == 0) begin : g_head
      assign s_in = iq_t'{q: sample_q, i: sample_i};
      assign u_in = '0;
    end else begin : g_body
      assign s_in = s_hist[Tc-1];
      assign u_in = u_line[Tc-1];
    end

    for (genvar Fc = 0; Fc < MAX_FACTOR; Fc++) begin : g_align
      localparam int Fv = Fc + 1;
      if ((Tc % Fv == 0) && (Tc >= Fv)) begin : g_hit
        assign cand[Fc] = s_hist[Tc/Fv - 1];
      end else begin : g_miss
        assign cand[Fc] = '0;
      end
    end

    always_comb begin
      load_v = '0;
      if (Tc == 0) begin
        if (is_push) begin
          load_v = iq_t'{q: sample_q, i: sample_i};
        end
      end else begin
        for (int k = 0; k < MAX_FACTOR; k++) begin
          if (f_eff == FE_W'(k + 1)) begin
            load_v = cand[k];
          end
        end
      end
    end

    assign tap_we = in_acc && is_load && (32'(tap_index) == Tc);
    assign in_use = (32'(m_eff) > Tc);

    ips_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .tap_we    (tap_we),
      .tap_value (tap_value),
      .in_use    (in_use),
      .s_prev    (s_in),
      .u_prev    (u_in),
      .u_load    (load_v),
      .s_out     (s_hist[Tc]),
      .u_out     (u_line[Tc]),
      .prod_i    (prod_i[Tc]),
      .prod_q    (prod_q[Tc])
    );
  end

  // Slot marks for the product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_flags_r <= '0;
    end else if (adv) begin
      prod_flags_r <= slot_flags_t'{valid: slot_v_r, last: slot_last_r};
    end
  end

  ips_sum_tree #(
    .N     (MAX_TAPS),
    .IN_W  (PROD_W),
    .OUT_W (SUM_W)
  ) u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .prod_i    (prod_i),
    .prod_q    (prod_q),
    .flags_in  (prod_flags_r),
    .sum_i     (sum_i),
    .sum_q     (sum_q),
    .flags_out (tree_flags)
  );

  // Round half up, then the shift by 15 is a bit-select.
  assign rnd_i = RND_W'(sum_i) + RND_W'(16384);
  assign rnd_q = RND_W'(sum_q) + RND_W'(16384);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tree_flags.valid;
      out_last_r  <= tree_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_i_r <= sat16(rnd_i[RND_W-1:15]);
      out_q_r <= sat16(rnd_q[RND_W-1:15]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_q_r, out_i_r};

`ifndef SYNTHESIS
  // A pushed sample always opens a run of outputs.
  a_push_issues: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_push |=> slot_v_r)
    else $error("push accepted without issuing an output slot");

  // A run that has not reached its last slot keeps issuing.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    slot_v_r && !slot_last_r && adv |=> slot_v_r)
    else $error("output run ended before its last slot");

  // The final slot of a run has nothing left to issue.
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    slot_v_r && slot_last_r |-> rem_r == '0)
    else $error("last slot marked while slots remain");

  // A flush leaves the sample history empty; the first and last entries are checked.
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_flush |=> (s_hist[0] == '0) && (s_hist[MAX_TAPS-1] == '0))
    else $error("sample history not cleared by flush");
`endif

endmodule
